### rtl/mfrh_pkg.sv
// Shared types and constants of the motor frame receive handler.
package mfrh_pkg;

    localparam int MOTOR_SLOTS = 4;
    localparam int SLOT_W      = $clog2(MOTOR_SLOTS);
    localparam int COUNT_W     = 3;
    localparam int ID_W        = 8;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;
    localparam int TIME_W      = 32;

    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_ARM   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [2:0] REG_HOST_ID       = 3'd0;
    localparam logic [2:0] REG_MOTOR_COUNT   = 3'd1;
    localparam logic [2:0] REG_SLOT_IDS      = 3'd2;
    localparam logic [2:0] REG_FAULT_TIMEOUT = 3'd3;
    localparam logic [2:0] REG_READ_TYPE     = 3'd4;
    localparam logic [2:0] REG_WRITE_TYPE    = 3'd5;

    localparam logic [15:0] FAULT_TIMEOUT_RST = 16'd100;
    localparam logic [2:0]  READ_TYPE_RST     = 3'd1;
    localparam logic [2:0]  WRITE_TYPE_RST    = 3'd2;

    typedef enum logic [2:0] {
        ST_FEEDBACK = 3'd0,
        ST_FAULT    = 3'd1,
        ST_PARAM    = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_BADTYPE  = 3'd4,
        ST_OK       = 3'd5
    } t_status;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic execute;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

### rtl/mfrh_ctrl.sv
// Sequencing state machine of the motor frame receive handler.
module mfrh_ctrl
    import mfrh_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;
    logic   n_in_stall;
    logic   accept;

    assign accept     = (r_state == S_IDLE) && !r_in_stall && i_in_valid;
    assign o_in_stall = r_in_stall;

    always_comb begin
        n_state       = r_state;
        n_in_stall    = r_in_stall;
        o_cmd.capture = 1'b0;
        o_cmd.lookup  = 1'b0;
        o_cmd.execute = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_in_stall = 1'b0;
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOOKUP;
                    n_in_stall    = 1'b1;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.execute = 1'b1;
                    n_state       = S_IDLE;
                    n_in_stall    = 1'b0;
                end
            end
            default: begin
                n_state    = S_IDLE;
                n_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_stall <= n_in_stall;
        end
    end

endmodule

### rtl/mfrh_dp.sv
// Datapath of the motor frame receive handler: registers, slot table and result.
module mfrh_dp
    import mfrh_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic [1:0]          i_op,
    input  logic [10:0]         i_std_id,
    input  logic [63:0]         i_payload,
    input  logic [TIME_W-1:0]   i_now_ms,
    input  logic [ID_W-1:0]     i_target_id,
    input  logic [TIME_W-1:0]   i_online_timeout_ms,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [2:0]          o_status,
    output logic [SLOT_W-1:0]   o_slot,
    output logic [15:0]         o_position_code,
    output logic [11:0]         o_velocity_code,
    output logic [11:0]         o_torque_code,
    output logic [11:0]         o_temperature_code,
    output logic [1:0]          o_motor_mode,
    output logic [31:0]         o_fault_word,
    output logic [15:0]         o_param_index,
    output logic [31:0]         o_param_value,
    output logic                o_online
);

    logic [ID_W-1:0]    r_host_id;
    logic [COUNT_W-1:0] r_motor_count;
    logic [31:0]        r_slot_ids;
    logic [15:0]        r_fault_timeout;
    logic [2:0]         r_read_type;
    logic [2:0]         r_write_type;
    logic               cfg_wr;

    logic [1:0]         r_op;
    logic [10:0]        r_std_id;
    logic [63:0]        r_payload;
    logic [TIME_W-1:0]  r_now;
    logic [ID_W-1:0]    r_target_id;
    logic [TIME_W-1:0]  r_otmo;

    logic               r_is_master;
    logic               r_hit;
    logic [SLOT_W-1:0]  r_slot;
    logic               n_is_master;
    logic               n_hit;
    logic [SLOT_W-1:0]  n_slot;
    logic [ID_W-1:0]    key;

    logic               r_seen     [MOTOR_SLOTS];
    logic [TIME_W-1:0]  r_last     [MOTOR_SLOTS];
    logic               r_pending  [MOTOR_SLOTS];
    logic [TIME_W-1:0]  r_deadline [MOTOR_SLOTS];

    logic [TIME_W-1:0]  deadline_diff;
    logic [TIME_W-1:0]  feedback_age;
    logic               pend_eff;
    logic               fault_hit;
    logic [2:0]         ftype;
    logic               type_ok;

    logic               r_out_valid;
    t_status            r_status;
    t_status            n_status;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [SLOT_W-1:0]  n_out_slot;
    logic [15:0]        r_pos,   n_pos;
    logic [11:0]        r_vel,   n_vel;
    logic [11:0]        r_trq,   n_trq;
    logic [11:0]        r_temp,  n_temp;
    logic [1:0]         r_mode,  n_mode;
    logic [31:0]        r_fault, n_fault;
    logic [15:0]        r_pidx,  n_pidx;
    logic [31:0]        r_pval,  n_pval;
    logic               r_online, n_online;
    logic               upd_feedback;
    logic               upd_pending;
    logic               n_pending;
    logic               upd_arm;

    // configuration port
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_id       <= '0;
            r_motor_count   <= '0;
            r_slot_ids      <= '0;
            r_fault_timeout <= FAULT_TIMEOUT_RST;
            r_read_type     <= READ_TYPE_RST;
            r_write_type    <= WRITE_TYPE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_HOST_ID:       r_host_id       <= pwdata[ID_W-1:0];
                REG_MOTOR_COUNT:   r_motor_count   <= pwdata[COUNT_W-1:0];
                REG_SLOT_IDS:      r_slot_ids      <= pwdata;
                REG_FAULT_TIMEOUT: r_fault_timeout <= pwdata[15:0];
                REG_READ_TYPE:     r_read_type     <= pwdata[2:0];
                REG_WRITE_TYPE:    r_write_type    <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_HOST_ID:       prdata = {{(DATA_W-ID_W){1'b0}}, r_host_id};
            REG_MOTOR_COUNT:   prdata = {{(DATA_W-COUNT_W){1'b0}}, r_motor_count};
            REG_SLOT_IDS:      prdata = r_slot_ids;
            REG_FAULT_TIMEOUT: prdata = {16'd0, r_fault_timeout};
            REG_READ_TYPE:     prdata = {29'd0, r_read_type};
            REG_WRITE_TYPE:    prdata = {29'd0, r_write_type};
            default:           prdata = '0;
        endcase
    end

    // capture the transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op        <= i_op;
            r_std_id    <= i_std_id;
            r_payload   <= i_payload;
            r_now       <= i_now_ms;
            r_target_id <= i_target_id;
            r_otmo      <= i_online_timeout_ms;
        end
    end

    // slot lookup, lowest matching slot wins
    assign n_is_master = (r_std_id == {3'd0, r_host_id});

    always_comb begin
        if (r_op != OP_FRAME) begin
            key = r_target_id;
        end else if (n_is_master) begin
            key = r_payload[7:0];
        end else begin
            key = r_std_id[7:0];
        end
        n_hit  = 1'b0;
        n_slot = '0;
        for (int i = MOTOR_SLOTS - 1; i >= 0; i--) begin
            if ((COUNT_W'(i) < r_motor_count) && (r_slot_ids[i*ID_W +: ID_W] == key)) begin
                n_hit  = 1'b1;
                n_slot = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_is_master <= n_is_master;
            r_hit       <= n_hit;
            r_slot      <= n_slot;
        end
    end

    // execute
    assign deadline_diff = r_now - r_deadline[r_slot];
    assign feedback_age  = r_now - r_last[r_slot];
    assign pend_eff      = r_pending[r_slot] && deadline_diff[TIME_W-1];
    assign fault_hit     = pend_eff && (r_payload[63:40] == 24'd0);
    assign ftype         = r_std_id[10:8];
    assign type_ok       = (ftype == r_read_type) || (ftype == r_write_type);

    always_comb begin
        n_status     = ST_BADTYPE;
        n_out_slot   = '0;
        n_pos        = '0;
        n_vel        = '0;
        n_trq        = '0;
        n_temp       = '0;
        n_mode       = '0;
        n_fault      = '0;
        n_pidx       = '0;
        n_pval       = '0;
        n_online     = 1'b0;
        upd_feedback = 1'b0;
        upd_pending  = 1'b0;
        n_pending    = 1'b0;
        upd_arm      = 1'b0;
        case (r_op)
            OP_FRAME: begin
                if (!r_hit) begin
                    n_status = ST_UNKNOWN;
                end else if (r_is_master) begin
                    n_out_slot  = r_slot;
                    upd_pending = 1'b1;
                    n_pending   = pend_eff && !fault_hit;
                    if (fault_hit) begin
                        n_status = ST_FAULT;
                        n_fault  = r_payload[39:8];
                    end else begin
                        n_status     = ST_FEEDBACK;
                        n_pos        = {r_payload[15:8], r_payload[23:16]};
                        n_vel        = {r_payload[31:24], r_payload[39:36]};
                        n_trq        = {r_payload[35:32], r_payload[47:40]};
                        n_temp       = {r_payload[51:48], r_payload[63:56]};
                        n_mode       = r_payload[55:54];
                        upd_feedback = 1'b1;
                    end
                end else begin
                    n_out_slot = r_slot;
                    if (type_ok) begin
                        n_status = ST_PARAM;
                        n_pidx   = r_payload[15:0];
                        n_pval   = r_payload[63:32];
                    end
                end
            end
            OP_ARM, OP_QUERY: begin
                if (!r_hit) begin
                    n_status = ST_UNKNOWN;
                end else begin
                    n_status   = ST_OK;
                    n_out_slot = r_slot;
                    if (r_op == OP_ARM) begin
                        upd_arm = 1'b1;
                    end else begin
                        n_online = r_seen[r_slot] && (feedback_age <= r_otmo);
                    end
                end
            end
            default: n_status = ST_BADTYPE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MOTOR_SLOTS; i++) begin
                r_seen[i]     <= 1'b0;
                r_last[i]     <= '0;
                r_pending[i]  <= 1'b0;
                r_deadline[i] <= '0;
            end
        end else if (i_cmd.execute) begin
            if (upd_feedback) begin
                r_seen[r_slot] <= 1'b1;
                r_last[r_slot] <= r_now;
            end
            if (upd_pending) begin
                r_pending[r_slot] <= n_pending;
            end
            if (upd_arm) begin
                r_pending[r_slot]  <= 1'b1;
                r_deadline[r_slot] <= r_now + {16'd0, r_fault_timeout};
            end
        end
    end

    // result register
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.execute) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_status   <= n_status;
            r_out_slot <= n_out_slot;
            r_pos      <= n_pos;
            r_vel      <= n_vel;
            r_trq      <= n_trq;
            r_temp     <= n_temp;
            r_mode     <= n_mode;
            r_fault    <= n_fault;
            r_pidx     <= n_pidx;
            r_pval     <= n_pval;
            r_online   <= n_online;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_slot             = r_out_slot;
    assign o_position_code    = r_pos;
    assign o_velocity_code    = r_vel;
    assign o_torque_code      = r_trq;
    assign o_temperature_code = r_temp;
    assign o_motor_mode       = r_mode;
    assign o_fault_word       = r_fault;
    assign o_param_index      = r_pidx;
    assign o_param_value      = r_pval;
    assign o_online           = r_online;

endmodule

### rtl/mit_motor_frame_receive_handler.sv
// Receive handler for frames of a four-slot motor table: top level.
// Each transaction (received frame, fault window arm, or online query)
// yields exactly one result. A transaction passes through three steps: capture,
// slot lookup across the four identifier comparators, and execute, where the
// slot state is updated and the result register loaded; the next transaction
// is taken the cycle after execute, so a new transaction is never taken before
// the last has executed. Execute waits while the result register still holds an
// untaken result. Configuration writes take effect at once and are meant for
// idle periods; position, velocity, torque and temperature are raw codes.
module mit_motor_frame_receive_handler
    import mfrh_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_op,
    input  logic [10:0]         i_std_id,
    input  logic [63:0]         i_payload,
    input  logic [TIME_W-1:0]   i_now_ms,
    input  logic [ID_W-1:0]     i_target_id,
    input  logic [TIME_W-1:0]   i_online_timeout_ms,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [2:0]          o_status,
    output logic [SLOT_W-1:0]   o_slot,
    output logic [15:0]         o_position_code,
    output logic [11:0]         o_velocity_code,
    output logic [11:0]         o_torque_code,
    output logic [11:0]         o_temperature_code,
    output logic [1:0]          o_motor_mode,
    output logic [31:0]         o_fault_word,
    output logic [15:0]         o_param_index,
    output logic [31:0]         o_param_value,
    output logic                o_online,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign pready = 1'b1;

    mfrh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    mfrh_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_op                (i_op),
        .i_std_id            (i_std_id),
        .i_payload           (i_payload),
        .i_now_ms            (i_now_ms),
        .i_target_id         (i_target_id),
        .i_online_timeout_ms (i_online_timeout_ms),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_status            (o_status),
        .o_slot              (o_slot),
        .o_position_code     (o_position_code),
        .o_velocity_code     (o_velocity_code),
        .o_torque_code       (o_torque_code),
        .o_temperature_code  (o_temperature_code),
        .o_motor_mode        (o_motor_mode),
        .o_fault_word        (o_fault_word),
        .o_param_index       (o_param_index),
        .o_param_value       (o_param_value),
        .o_online            (o_online)
    );

endmodule

### rtl/mfrh_chk.sv
// Port-level checker of the motor frame receive handler and its bind.
module mfrh_chk
    import mfrh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              o_in_stall,
    input  logic              o_out_valid,
    input  logic              i_out_stall,
    input  logic [2:0]        o_status,
    input  logic [SLOT_W-1:0] o_slot,
    input  logic              o_online
);

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_accept_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled while a transaction is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status)))
        else $error("stalled result dropped or changed");

    a_unknown_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_UNKNOWN)) |-> (o_slot == '0))
        else $error("unknown motor reports a slot");

    a_online_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> !o_online)
        else $error("online flag on a result that is not a query answer");

endmodule

bind mit_motor_frame_receive_handler mfrh_chk u_chk (.*);

### tb/mit_motor_frame_receive_handler_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the motor frame receive handler, with its own prediction.
module mit_motor_frame_receive_handler_test;
    import mfrh_pkg::*;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 135;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 200;
    localparam int QUIET_LIMIT  = 3000;

    localparam logic [1:0] OP_UNDEFINED = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [10:0] std_id;
        logic [63:0] payload;
        logic [31:0] now_ms;
        logic [7:0]  target_id;
        logic [31:0] online_timeout_ms;
    } t_frame_item;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       position_code;
        logic [11:0]       velocity_code;
        logic [11:0]       torque_code;
        logic [11:0]       temperature_code;
        logic [1:0]        motor_mode;
        logic [31:0]       fault_word;
        logic [15:0]       param_index;
        logic [31:0]       param_value;
        logic              online;
    } t_frame_result;

    class frame_scoreboard;
        logic [7:0]    host_id;
        logic [2:0]    motor_count;
        logic [31:0]   slot_ids;
        logic [15:0]   fault_timeout;
        logic [2:0]    read_type;
        logic [2:0]    write_type;
        logic          fb_seen [MOTOR_SLOTS];
        logic [31:0]   fb_time [MOTOR_SLOTS];
        logic          window_open [MOTOR_SLOTS];
        logic [31:0]   window_deadline [MOTOR_SLOTS];
        t_frame_result expected_q[$];
        int            errors;

        function new();
            host_id       = '0;
            motor_count   = '0;
            slot_ids      = '0;
            fault_timeout = FAULT_TIMEOUT_RST;
            read_type     = READ_TYPE_RST;
            write_type    = WRITE_TYPE_RST;
            errors        = 0;
            for (int i = 0; i < MOTOR_SLOTS; i++) begin
                fb_seen[i]         = 1'b0;
                fb_time[i]         = '0;
                window_open[i]     = 1'b0;
                window_deadline[i] = '0;
            end
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_HOST_ID:       host_id       = value[7:0];
                REG_MOTOR_COUNT:   motor_count   = value[2:0];
                REG_SLOT_IDS:      slot_ids      = value;
                REG_FAULT_TIMEOUT: fault_timeout = value[15:0];
                REG_READ_TYPE:     read_type     = value[2:0];
                REG_WRITE_TYPE:    write_type    = value[2:0];
                default: ;
            endcase
        endfunction

        function int slot_of(logic [7:0] id);
            int n;
            n = (motor_count > MOTOR_SLOTS) ? MOTOR_SLOTS : int'(motor_count);
            if (n > 4) n = 4;
            for (int i = 0; i < n; i++)
                if (slot_ids[8*i +: 8] == id) return i;
            return -1;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the slot table and queue the result that this transaction owes.
        function void note_frame(t_frame_item it);
            t_frame_result r;
            logic [7:0]    b [8];
            logic [31:0]   since;
            int            s;
            r = '0;
            for (int k = 0; k < 8; k++) b[k] = it.payload[8*k +: 8];
            if (it.op == OP_FRAME && it.std_id == {3'b000, host_id}) begin
                s = slot_of(b[0]);
                if (s < 0) begin
                    r.status = ST_UNKNOWN;
                end else begin
                    r.slot = s[SLOT_W-1:0];
                    since = it.now_ms - window_deadline[s];
                    if (window_open[s] && !since[31]) window_open[s] = 1'b0;
                    if (window_open[s] && {b[5], b[6], b[7]} == 24'h0) begin
                        r.status       = ST_FAULT;
                        r.fault_word   = it.payload[39:8];
                        window_open[s] = 1'b0;
                    end else begin
                        r.status           = ST_FEEDBACK;
                        r.position_code    = {b[1], b[2]};
                        r.velocity_code    = {b[3], b[4][7:4]};
                        r.torque_code      = {b[4][3:0], b[5]};
                        r.temperature_code = {b[6][3:0], b[7]};
                        r.motor_mode       = b[6][7:6];
                        fb_seen[s]         = 1'b1;
                        fb_time[s]         = it.now_ms;
                    end
                end
            end else if (it.op == OP_FRAME) begin
                s = slot_of(it.std_id[7:0]);
                if (s < 0) begin
                    r.status = ST_UNKNOWN;
                end else begin
                    r.slot = s[SLOT_W-1:0];
                    if (it.std_id[10:8] != read_type && it.std_id[10:8] != write_type) begin
                        r.status = ST_BADTYPE;
                    end else begin
                        r.status      = ST_PARAM;
                        r.param_index = it.payload[15:0];
                        r.param_value = it.payload[63:32];
                    end
                end
            end else if (it.op == OP_ARM || it.op == OP_QUERY) begin
                s = slot_of(it.target_id);
                if (s < 0) begin
                    r.status = ST_UNKNOWN;
                end else begin
                    r.slot   = s[SLOT_W-1:0];
                    r.status = ST_OK;
                    if (it.op == OP_ARM) begin
                        window_open[s]     = 1'b1;
                        window_deadline[s] = it.now_ms + {16'h0, fault_timeout};
                    end else begin
                        since    = it.now_ms - fb_time[s];
                        r.online = fb_seen[s] && since <= it.online_timeout_ms;
                    end
                end
            end else begin
                r.status = ST_BADTYPE;
            end
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_frame_result got);
            t_frame_result want;
            if (expected_q.size() == 0) begin
                $error("result with no transaction outstanding, status %0d", got.status);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("slot", want.slot, got.slot);
            compare_field("position_code", want.position_code, got.position_code);
            compare_field("velocity_code", want.velocity_code, got.velocity_code);
            compare_field("torque_code", want.torque_code, got.torque_code);
            compare_field("temperature_code", want.temperature_code, got.temperature_code);
            compare_field("motor_mode", want.motor_mode, got.motor_mode);
            compare_field("fault_word", want.fault_word, got.fault_word);
            compare_field("param_index", want.param_index, got.param_index);
            compare_field("param_value", want.param_value, got.param_value);
            compare_field("online", want.online, got.online);
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [1:0]          i_op;
    logic [10:0]         i_std_id;
    logic [63:0]         i_payload;
    logic [TIME_W-1:0]   i_now_ms;
    logic [ID_W-1:0]     i_target_id;
    logic [TIME_W-1:0]   i_online_timeout_ms;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [2:0]          o_status;
    logic [SLOT_W-1:0]   o_slot;
    logic [15:0]         o_position_code;
    logic [11:0]         o_velocity_code;
    logic [11:0]         o_torque_code;
    logic [11:0]         o_temperature_code;
    logic [1:0]          o_motor_mode;
    logic [31:0]         o_fault_word;
    logic [15:0]         o_param_index;
    logic [31:0]         o_param_value;
    logic                o_online;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    frame_scoreboard sb;
    bit              idle_on = 1'b1;
    bit              long_hold_req = 1'b0;
    logic [31:0]     now_track;

    mit_motor_frame_receive_handler dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_op                (i_op),
        .i_std_id            (i_std_id),
        .i_payload           (i_payload),
        .i_now_ms            (i_now_ms),
        .i_target_id         (i_target_id),
        .i_online_timeout_ms (i_online_timeout_ms),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_slot              (o_slot),
        .o_position_code     (o_position_code),
        .o_velocity_code     (o_velocity_code),
        .o_torque_code       (o_torque_code),
        .o_temperature_code  (o_temperature_code),
        .o_motor_mode        (o_motor_mode),
        .o_fault_word        (o_fault_word),
        .o_param_index       (o_param_index),
        .o_param_value       (o_param_value),
        .o_online            (o_online),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    always #1 i_clk = ~i_clk;

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, value);
    endtask

    task automatic configure(logic [7:0] master, logic [2:0] count, logic [31:0] ids,
                             logic [15:0] timeout, logic [2:0] rd_type, logic [2:0] wr_type);
        write_reg(REG_HOST_ID, {24'h0, master});
        write_reg(REG_MOTOR_COUNT, {29'h0, count});
        write_reg(REG_SLOT_IDS, ids);
        write_reg(REG_FAULT_TIMEOUT, {16'h0, timeout});
        write_reg(REG_READ_TYPE, {29'h0, rd_type});
        write_reg(REG_WRITE_TYPE, {29'h0, wr_type});
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_item(t_frame_item it);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_op                <= it.op;
        i_std_id            <= it.std_id;
        i_payload           <= it.payload;
        i_now_ms            <= it.now_ms;
        i_target_id         <= it.target_id;
        i_online_timeout_ms <= it.online_timeout_ms;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_frame(it);
    endtask

    // Hold off until every result is back and the block has gone quiet.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_frame_item frame_item(logic [1:0] op, logic [10:0] id,
                                               logic [63:0] data, logic [31:0] now,
                                               logic [7:0] mid, logic [31:0] otmo);
        t_frame_item it;
        it.op                = op;
        it.std_id            = id;
        it.payload           = data;
        it.now_ms            = now;
        it.target_id         = mid;
        it.online_timeout_ms = otmo;
        return it;
    endfunction

    function automatic logic [7:0] pick_id();
        if ($urandom_range(0, 6) == 0) return 8'($urandom);
        return sb.slot_ids[8*$urandom_range(0, 3) +: 8];
    endfunction

    function automatic t_frame_item random_item();
        t_frame_item it;
        int          pick;
        if ($urandom_range(0, 49) == 0) now_track = $urandom;
        else now_track = now_track + $urandom_range(0, 60);
        it.op                = OP_FRAME;
        it.std_id            = 11'($urandom);
        it.payload           = {$urandom, $urandom};
        it.now_ms            = now_track;
        it.target_id         = pick_id();
        it.online_timeout_ms = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 120);
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            it.std_id        = {3'b000, sb.host_id};
            it.payload[7:0]  = pick_id();
            if ($urandom_range(0, 2) == 0) it.payload[63:40] = '0;
        end else if (pick < 50) begin
            it.op = OP_ARM;
        end else if (pick < 65) begin
            it.op = OP_QUERY;
        end else if (pick < 85) begin
            case ($urandom_range(0, 2))
                0:       it.std_id[10:8] = sb.read_type;
                1:       it.std_id[10:8] = sb.write_type;
                default: it.std_id[10:8] = 3'($urandom);
            endcase
            it.std_id[7:0] = pick_id();
        end else if (pick >= 95) begin
            it.op        = 2'($urandom);
            it.target_id = 8'($urandom);
        end
        return it;
    endfunction

    initial begin : result_sink
        int            hold_left;
        t_frame_result got;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.status           = t_status'(o_status);
                got.slot             = o_slot;
                got.position_code    = o_position_code;
                got.velocity_code    = o_velocity_code;
                got.torque_code      = o_torque_code;
                got.temperature_code = o_temperature_code;
                got.motor_mode       = o_motor_mode;
                got.fault_word       = o_fault_word;
                got.param_index      = o_param_index;
                got.param_value      = o_param_value;
                got.online           = o_online;
                sb.check_result(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                if (hold_left == 0) i_out_stall <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                hold_left = LONG_HOLD;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
                i_out_stall <= 1'b1;
                hold_left = $urandom_range(1, 13);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("mit_motor_frame_receive_handler_test failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [31:0] ids;
        sb = new();
        i_rst_n             <= 1'b0;
        i_in_valid          <= 1'b0;
        i_op                <= OP_FRAME;
        i_std_id            <= '0;
        i_payload           <= '0;
        i_now_ms            <= '0;
        i_target_id         <= '0;
        i_online_timeout_ms <= '0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        configure(8'hA5, 3'd4, 32'hFF80_0100, 16'd100, 3'd7, 3'd0);
        send_item(frame_item(OP_FRAME, 11'h0A5, 64'hFFFF_FFFF_FFFF_FF00, 32'd10, 8'h00, 32'd0));
        send_item(frame_item(OP_FRAME, 11'h0A5, 64'h0000_0000_0000_00FF, 32'd10, 8'h00, 32'd0));
        send_item(frame_item(OP_QUERY, 11'h000, 64'h0, 32'd10, 8'h00, 32'd0));
        send_item(frame_item(OP_QUERY, 11'h000, 64'h0, 32'd11, 8'h00, 32'd0));
        send_item(frame_item(OP_QUERY, 11'h7FF, 64'h0, 32'd11, 8'h00, 32'hFFFF_FFFF));
        send_item(frame_item(OP_QUERY, 11'h000, 64'h0, 32'd11, 8'h01, 32'hFFFF_FFFF));
        // window answered in time, then closed
        send_item(frame_item(OP_ARM, 11'h000, 64'h0, 32'd1000, 8'h80, 32'd0));
        send_item(frame_item(OP_FRAME, 11'h0A5, 64'h0000_00DE_ADBE_EF80, 32'd1050, 8'h00, 32'd0));
        send_item(frame_item(OP_FRAME, 11'h0A5, 64'h0000_00DE_ADBE_EF80, 32'd1060, 8'h00, 32'd0));
        // window reached its deadline exactly
        send_item(frame_item(OP_ARM, 11'h000, 64'h0, 32'd2000, 8'hFF, 32'd0));
        send_item(frame_item(OP_FRAME, 11'h0A5, 64'h0000_0012_3456_78FF, 32'd2100, 8'h00, 32'd0));
        // deadline wraps past zero
        send_item(frame_item(OP_ARM, 11'h000, 64'h0, 32'hFFFF_FFF0, 8'h01, 32'd0));
        send_item(frame_item(OP_FRAME, 11'h0A5, 64'h0000_00FF_FFFF_FF01, 32'd5, 8'h00, 32'd0));
        // feedback inside an open window leaves it open
        send_item(frame_item(OP_ARM, 11'h000, 64'h0, 32'd3000, 8'h00, 32'd0));
        send_item(frame_item(OP_FRAME, 11'h0A5, 64'h0100_0000_0000_0000, 32'd3001, 8'h00, 32'd0));
        send_item(frame_item(OP_FRAME, 11'h0A5, 64'h0, 32'd3002, 8'h00, 32'd0));
        send_item(frame_item(OP_FRAME, 11'h0A5, 64'h0000_0000_0000_0042, 32'd3003, 8'h00, 32'd0));
        send_item(frame_item(OP_FRAME, 11'h701, 64'hFFFF_FFFF_FFFF_FFFF, 32'd3004, 8'h00, 32'd0));
        send_item(frame_item(OP_FRAME, 11'h080, 64'h1234_5678_9ABC_DEF0, 32'd3005, 8'h00, 32'd0));
        send_item(frame_item(OP_FRAME, 11'h1FF, 64'h55, 32'd3006, 8'h00, 32'd0));
        send_item(frame_item(OP_FRAME, 11'h742, 64'h0, 32'd3007, 8'h00, 32'd0));
        send_item(frame_item(OP_ARM, 11'h000, 64'h0, 32'd3008, 8'h42, 32'd0));
        send_item(frame_item(OP_QUERY, 11'h000, 64'h0, 32'd3009, 8'h42, 32'hFFFF_FFFF));
        send_item(frame_item(OP_UNDEFINED, 11'h0A5, 64'h0, 32'd3010, 8'h00, 32'd0));
        send_item(frame_item(OP_FRAME, 11'h7FF, 64'hFFFF_FFFF_0000_ABCD, 32'd3011, 8'h00, 32'd0));

        for (int phase = 1; phase <= PHASES; phase++) begin
            settle();
            if (phase == PHASES) idle_on = 1'b0;
            ids = $urandom;
            if ($urandom_range(0, 2) == 0) ids[8*$urandom_range(1, 3) +: 8] = ids[7:0];
            case (phase)
                1:       configure(8'hFF, 3'd7, ids, 16'hFFFF, 3'd7, 3'd7);
                2:       configure(8'h00, 3'd0, 32'h0, 16'h0, 3'd0, 3'd0);
                default: configure(8'($urandom),
                                   ($urandom_range(0, 2) == 0) ? 3'($urandom) : 3'd4, ids,
                                   ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                               : 16'($urandom_range(0, 150)),
                                   3'($urandom), 3'($urandom));
            endcase
            now_track = $urandom;
            if (phase == 4) long_hold_req = 1'b1;
            repeat (PHASE_ITEMS) send_item(random_item());
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("mit_motor_frame_receive_handler_test passed");
        else
            $display("mit_motor_frame_receive_handler_test failed");
        $finish;
    end

endmodule
